[hw/rtl/fenp_pkg.sv]
`default_nettype none

package fenp_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } fenp_in_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  square;
    logic [3:0]  piece_code;
    logic [3:0]  error_code;
    logic        white_moves;
    logic [3:0]  castle_rights;
    logic        passant_valid;
    logic [2:0]  passant_file;
    logic [2:0]  passant_rank;
    logic [15:0] halfmove_count;
    logic [15:0] fullmove_count;
    logic        run_last;
  } fenp_out_t;

  typedef struct packed {
    logic [3:0]  error_code;
    logic        white_moves;
    logic [3:0]  castle_rights;
    logic        passant_valid;
    logic [2:0]  passant_file;
    logic [2:0]  passant_rank;
    logic [15:0] halfmove_count;
    logic [15:0] fullmove_count;
  } fenp_rpt_t;

  typedef struct packed {
    logic [3:0] wr_cnt;
    logic [5:0] square;
    logic [3:0] piece;
    logic       rpt;
    fenp_rpt_t  rpt_data;
  } fenp_job_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_SHORT_RANK  = 4'd1,
    ERR_MANY_RANKS  = 4'd2,
    ERR_BAD_DIGIT   = 4'd3,
    ERR_RANK_OVF    = 4'd4,
    ERR_NOT_8_RANKS = 4'd5,
    ERR_FEW_FIELDS  = 4'd6,
    ERR_BAD_SIDE    = 4'd7,
    ERR_BAD_CASTLE  = 4'd8,
    ERR_EP_LENGTH   = 4'd9,
    ERR_EP_FILE     = 4'd10,
    ERR_EP_RANK     = 4'd11,
    ERR_BAD_NUMBER  = 4'd12
  } fenp_err_e;

  localparam logic [2:0] FIELD_BOARD    = 3'd0;
  localparam logic [2:0] FIELD_SIDE     = 3'd1;
  localparam logic [2:0] FIELD_CASTLE   = 3'd2;
  localparam logic [2:0] FIELD_PASSANT  = 3'd3;
  localparam logic [2:0] FIELD_HALFMOVE = 3'd4;
  localparam logic [2:0] FIELD_FULLMOVE = 3'd5;
  localparam logic [2:0] FIELD_EXTRA    = 3'd6;
  localparam logic [2:0] FIELD_SAT      = 3'd7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_H_LO  = 8'h68;
  localparam logic [7:0] CH_W_LO  = 8'h77;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_K_UP  = 8'h4B;
  localparam logic [7:0] CH_Q_UP  = 8'h51;
  localparam logic [7:0] CH_K_LO  = 8'h6B;
  localparam logic [7:0] CH_Q_LO  = 8'h71;

  localparam logic [3:0] PIECE_EMPTY = 4'd0;

  function automatic logic [3:0] piece_of(input logic [7:0] c);
    logic [3:0] p;
    case (c)
      8'h50:   p = 4'd1;
      8'h4E:   p = 4'd2;
      8'h42:   p = 4'd3;
      8'h52:   p = 4'd4;
      8'h51:   p = 4'd5;
      8'h4B:   p = 4'd6;
      8'h70:   p = 4'd7;
      8'h6E:   p = 4'd8;
      8'h62:   p = 4'd9;
      8'h72:   p = 4'd10;
      8'h71:   p = 4'd11;
      8'h6B:   p = 4'd12;
      default: p = PIECE_EMPTY;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fenp_parse.sv]
`default_nettype none

module fenp_parse #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire fenp_pkg::fenp_in_t  in_i,
  output logic                     job_valid_o,
  output fenp_pkg::fenp_job_t      job_o
);
  import fenp_pkg::*;

  localparam int CB = COUNTER_BITS;

  logic [2:0]    field_q, field_d;
  logic          in_space_q, in_space_d;
  logic [2:0]    rank_q, rank_d;
  logic [3:0]    file_q, file_d;
  logic [2:0]    tlen_q, tlen_d;
  fenp_err_e     err_q, err_d;
  logic          side_q, side_d;
  logic [3:0]    castle_q, castle_d;
  logic          cdash_q, cdash_d;
  logic [6:0]    ep_q, ep_d;
  logic [CB-1:0] half_q, half_d;
  logic [CB-1:0] full_q, full_d;
  logic [7:0]    epc0_q, epc0_d;
  logic [7:0]    epc1_q, epc1_d;
  logic          epdash_q, epdash_d;

  logic [7:0]    ch;
  logic          ws;
  logic          is_digit;
  logic [3:0]    dcnt;
  logic [4:0]    fsum;
  logic          num_ok;
  logic [CB+3:0] half_mac, full_mac;
  logic [CB-1:0] half_sat, full_sat;
  logic [31:0]   half_w, full_w;

  assign ch       = in_i.char_in;
  assign ws       = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign dcnt     = ch[3:0];
  assign fsum     = 5'(file_q) + 5'(dcnt);
  assign num_ok   = is_digit;

  assign half_mac = ({4'b0, half_q} << 3) + ({4'b0, half_q} << 1) + (CB+4)'(dcnt);
  assign full_mac = ({4'b0, full_q} << 3) + ({4'b0, full_q} << 1) + (CB+4)'(dcnt);
  assign half_sat = (|half_mac[CB+3:CB]) ? {CB{1'b1}} : half_mac[CB-1:0];
  assign full_sat = (|full_mac[CB+3:CB]) ? {CB{1'b1}} : full_mac[CB-1:0];

  always_comb begin
    field_d   = field_q;
    in_space_d = in_space_q;
    rank_d    = rank_q;
    file_d    = file_q;
    tlen_d    = tlen_q;
    err_d     = err_q;
    side_d    = side_q;
    castle_d  = castle_q;
    cdash_d   = cdash_q;
    ep_d      = ep_q;
    half_d    = half_q;
    full_d    = full_q;
    epc0_d    = epc0_q;
    epc1_d    = epc1_q;
    epdash_d  = epdash_q;
    job_o     = '0;
    half_w    = '0;
    full_w    = '0;

    if (!ws) begin
      if (in_space_q) begin
        tlen_d = '0;
      end
      in_space_d = 1'b0;
      if (err_q == ERR_NONE && field_q < FIELD_EXTRA) begin
        case (field_q)
          FIELD_BOARD: begin
            if (ch == CH_SLASH) begin
              if (file_q != 4'd8) begin
                err_d = ERR_SHORT_RANK;
              end else if (rank_q == 3'd0) begin
                err_d = ERR_MANY_RANKS;
              end else begin
                rank_d = rank_q - 3'd1;
                file_d = '0;
              end
            end else if (is_digit) begin
              if (dcnt == 4'd0 || dcnt == 4'd9) begin
                err_d = ERR_BAD_DIGIT;
              end else if (fsum > 5'd8) begin
                err_d = ERR_RANK_OVF;
              end else begin
                job_o.wr_cnt = dcnt;
                job_o.square = {rank_q, file_q[2:0]};
                job_o.piece  = PIECE_EMPTY;
                file_d       = fsum[3:0];
              end
            end else begin
              if (file_q >= 4'd8) begin
                err_d = ERR_RANK_OVF;
              end else begin
                job_o.wr_cnt = 4'd1;
                job_o.square = {rank_q, file_q[2:0]};
                job_o.piece  = piece_of(ch);
                file_d       = file_q + 4'd1;
              end
            end
          end
          FIELD_SIDE: begin
            if (tlen_d != 3'd0) begin
              err_d = ERR_BAD_SIDE;
            end else if (ch == CH_W_LO) begin
              side_d = 1'b1;
            end else if (ch == CH_B_LO) begin
              side_d = 1'b0;
            end else begin
              err_d = ERR_BAD_SIDE;
            end
          end
          FIELD_CASTLE: begin
            if (cdash_q) begin
              err_d = ERR_BAD_CASTLE;
            end else if (ch == CH_DASH && tlen_d == 3'd0) begin
              cdash_d = 1'b1;
            end else if (ch == CH_K_UP) begin
              castle_d = castle_q | 4'b0001;
            end else if (ch == CH_Q_UP) begin
              castle_d = castle_q | 4'b0010;
            end else if (ch == CH_K_LO) begin
              castle_d = castle_q | 4'b0100;
            end else if (ch == CH_Q_LO) begin
              castle_d = castle_q | 4'b1000;
            end else begin
              err_d = ERR_BAD_CASTLE;
            end
          end
          FIELD_PASSANT: begin
            if (tlen_d == 3'd0) begin
              epc0_d   = ch;
              epdash_d = (ch == CH_DASH);
            end else if (tlen_d == 3'd1) begin
              epc1_d = ch;
            end
          end
          FIELD_HALFMOVE: begin
            if (num_ok) begin
              half_d = half_sat;
            end else begin
              err_d = ERR_BAD_NUMBER;
            end
          end
          FIELD_FULLMOVE: begin
            if (num_ok) begin
              full_d = full_sat;
            end else begin
              err_d = ERR_BAD_NUMBER;
            end
          end
          default: begin
          end
        endcase
      end
      if (tlen_d < 3'd7) begin
        tlen_d = tlen_d + 3'd1;
      end
    end

    // close the token on a separator or on the final character
    if ((ws && !in_space_q) || (!ws && in_i.end_of_text)) begin
      if (err_d == ERR_NONE) begin
        if (field_d == FIELD_BOARD) begin
          if (rank_d != 3'd0 || file_d != 4'd8) begin
            err_d = ERR_NOT_8_RANKS;
          end
        end else if (field_d == FIELD_PASSANT) begin
          if (tlen_d == 3'd1 && epdash_d) begin
            ep_d = '0;
          end else if (tlen_d != 3'd2) begin
            err_d = ERR_EP_LENGTH;
          end else if (epc0_d < CH_A_LO || epc0_d > CH_H_LO) begin
            err_d = ERR_EP_FILE;
          end else if (epc1_d < CH_1 || epc1_d > CH_8) begin
            err_d = ERR_EP_RANK;
          end else begin
            ep_d = {1'b1, 3'(epc0_d - CH_A_LO), 3'(epc1_d - CH_1)};
          end
        end
      end
      if (field_d < FIELD_SAT) begin
        field_d = field_d + 3'd1;
      end
      in_space_d = 1'b1;
    end

    if (in_i.end_of_text) begin
      half_w = 32'(half_d);
      full_w = 32'(full_d);
      job_o.rpt = 1'b1;
      job_o.rpt_data.error_code     = (field_d < FIELD_EXTRA) ? ERR_FEW_FIELDS : err_d;
      job_o.rpt_data.white_moves    = side_d;
      job_o.rpt_data.castle_rights  = castle_d;
      job_o.rpt_data.passant_valid  = ep_d[6];
      job_o.rpt_data.passant_file   = ep_d[5:3];
      job_o.rpt_data.passant_rank   = ep_d[2:0];
      job_o.rpt_data.halfmove_count = half_w[15:0];
      job_o.rpt_data.fullmove_count = full_w[15:0];
      field_d    = FIELD_BOARD;
      in_space_d = 1'b1;
      rank_d     = 3'd7;
      file_d     = '0;
      tlen_d     = '0;
      err_d      = ERR_NONE;
      side_d     = 1'b1;
      castle_d   = '0;
      cdash_d    = 1'b0;
      ep_d       = '0;
      half_d     = '0;
      full_d     = '0;
      epc0_d     = '0;
      epc1_d     = '0;
      epdash_d   = 1'b0;
    end
  end

  assign job_valid_o = (job_o.wr_cnt != 4'd0) || job_o.rpt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q    <= FIELD_BOARD;
      in_space_q <= 1'b1;
      rank_q     <= 3'd7;
      file_q     <= '0;
      tlen_q     <= '0;
      err_q      <= ERR_NONE;
      side_q     <= 1'b1;
      castle_q   <= '0;
      cdash_q    <= 1'b0;
      ep_q       <= '0;
      half_q     <= '0;
      full_q     <= '0;
      epc0_q     <= '0;
      epc1_q     <= '0;
      epdash_q   <= 1'b0;
    end else if (accept_i) begin
      field_q    <= field_d;
      in_space_q <= in_space_d;
      rank_q     <= rank_d;
      file_q     <= file_d;
      tlen_q     <= tlen_d;
      err_q      <= err_d;
      side_q     <= side_d;
      castle_q   <= castle_d;
      cdash_q    <= cdash_d;
      ep_q       <= ep_d;
      half_q     <= half_d;
      full_q     <= full_d;
      epc0_q     <= epc0_d;
      epc1_q     <= epc1_d;
      epdash_q   <= epdash_d;
    end
  end

`ifndef SYNTHESIS
  a_file_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    file_q <= 4'd8)
    else $error("file position past the end of the rank");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && err_q != ERR_NONE && !in_i.end_of_text |=> err_q == $past(err_q))
    else $error("first error overwritten");

  a_write_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && job_o.wr_cnt != 4'd0 |-> 5'(job_o.square[2:0]) + 5'(job_o.wr_cnt) <= 5'd8)
    else $error("square writes cross a rank boundary");
`endif

endmodule

`default_nettype wire

[hw/rtl/fen_position_parser_core.sv]
// A character's results pass the pending job register and then the output register.
// Throughput: one character per cycle while each character yields at most one result
// with no output stall; a character with more results holds the single result emitter
// until its last result is emitted (up to 9 results). The output register takes the
// next result in the cycle the current one is taken. Reset: rst_ni low clears the
// parse state to the start of a new string and drops all pending results.
`default_nettype none

module fen_position_parser_core #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire fenp_pkg::fenp_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output fenp_pkg::fenp_out_t      out_data_o
);
  import fenp_pkg::*;

  logic      accept;
  logic      new_valid;
  fenp_job_t new_job;

  logic      job_valid_q, job_valid_d;
  fenp_job_t job_q, job_d;
  logic      out_valid_q, out_valid_d;
  fenp_out_t out_q, out_d;

  logic      out_free;
  logic      emit;
  logic      job_last;

  fenp_parse #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_data_i),
    .job_valid_o(new_valid),
    .job_o      (new_job)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = job_valid_q && out_free;
  assign job_last   = emit && ((job_q.wr_cnt == 4'd1 && !job_q.rpt) || job_q.wr_cnt == 4'd0);
  assign in_ready_o = !job_valid_q || job_last;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    job_valid_d = job_valid_q;
    job_d       = job_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (job_q.wr_cnt != 4'd0) begin
        out_d.square     = job_q.square;
        out_d.piece_code = job_q.piece;
        out_d.run_last   = (job_q.wr_cnt == 4'd1) && !job_q.rpt;
        job_d.wr_cnt     = job_q.wr_cnt - 4'd1;
        job_d.square     = job_q.square + 6'd1;
      end else begin
        out_d.kind           = 1'b1;
        out_d.error_code     = job_q.rpt_data.error_code;
        out_d.white_moves    = job_q.rpt_data.white_moves;
        out_d.castle_rights  = job_q.rpt_data.castle_rights;
        out_d.passant_valid  = job_q.rpt_data.passant_valid;
        out_d.passant_file   = job_q.rpt_data.passant_file;
        out_d.passant_rank   = job_q.rpt_data.passant_rank;
        out_d.halfmove_count = job_q.rpt_data.halfmove_count;
        out_d.fullmove_count = job_q.rpt_data.fullmove_count;
        out_d.run_last       = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      job_valid_d = new_valid;
      job_d       = new_job;
    end else if (job_last) begin
      job_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && job_q.wr_cnt == 4'd0 |-> job_q.rpt)
    else $error("pending job with nothing to emit");

  a_job_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> job_q.wr_cnt <= 4'd8)
    else $error("pending write count out of range");

  a_accept_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && job_valid_q |-> job_last)
    else $error("new character taken over a pending job");

  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind |-> out_data_o.run_last)
    else $error("report is not the last result of its character");
`endif

endmodule

`default_nettype wire
